### src/oaids_pkg.sv
// Shared types, constants and control/status bundles for the ordered array block.
`default_nettype none

package oaids_pkg;

  // Store geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int DATA_W = 32;

  // Opcodes of a request transaction (codes 6 and 7 are ignored)
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_SEARCH = 3'd4,
    OP_READ   = 3'd5
  } opcode_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [ADDR_W-1:0]        position;
    logic signed [DATA_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic [ADDR_W-1:0]        result_index;
    logic signed [DATA_W-1:0] result_value;
    logic [CNT_W-1:0]         fill_count;
  } rsp_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CAP,
    S_DEL_CHK,
    S_DEL_WR,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_RD_CAP,
    S_RESP
  } state_t;

  // Datapath selectors
  typedef enum logic [1:0] {ADDR_COUNT, ADDR_POS, ADDR_K, ADDR_KM1} addr_sel_t;
  typedef enum logic {WD_VAL, WD_RDATA} wdata_sel_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_CLEAR, CNT_INC, CNT_DEC} cnt_op_t;
  typedef enum logic [2:0] {K_HOLD, K_LOAD_COUNT, K_LOAD_ZERO, K_LOAD_POS1, K_INC, K_DEC} k_op_t;
  typedef enum logic [1:0] {RIDX_HOLD, RIDX_POS, RIDX_COUNT, RIDX_K} ridx_op_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch;
    logic       ram_en;
    logic       ram_we;
    addr_sel_t  addr_sel;
    wdata_sel_t wdata_sel;
    cnt_op_t    cnt_op;
    k_op_t      k_op;
    logic       status_we;
    status_t    status;
    ridx_op_t   ridx_op;
    logic       rval_cap;
    logic       out_load;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            pos_gt_cnt;
    logic            pos_ge_cnt;
    logic            k_gt_pos;
    logic            k_lt_cnt;
    logic            match;
    logic            out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

### src/oaids_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module oaids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: write, or read into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### src/oaids_datapath.sv
// Datapath: item registers, fill count, walk cursor, element RAM and response register.
`default_nettype none

module oaids_datapath import oaids_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire req_t     req,
  input  wire ctl_cmd_t cmd,
  output dp_stat_t      stat,
  input  wire logic     rsp_ready,
  output logic          rsp_valid,
  output rsp_t          rsp
);

  logic [OP_W-1:0]          op;
  logic [ADDR_W-1:0]        pos;
  logic signed [DATA_W-1:0] val;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         k;
  logic [CNT_W-1:0]         km1;
  status_t                  res_status;
  logic [ADDR_W-1:0]        res_index;
  logic signed [DATA_W-1:0] res_value;

  logic [ADDR_W-1:0] ram_addr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  assign km1 = k - CNT_W'(1);

  // Captured transaction
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op  <= req.opcode;
      pos <= req.position;
      val <= req.item_value;
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.cnt_op)
        CNT_CLEAR: count <= '0;
        CNT_INC:   count <= count + CNT_W'(1);
        CNT_DEC:   count <= count - CNT_W'(1);
        default:   count <= count;
      endcase
    end
  end

  // Walk cursor
  always_ff @(posedge clk) begin
    unique case (cmd.k_op)
      K_LOAD_COUNT: k <= count;
      K_LOAD_ZERO:  k <= '0;
      K_LOAD_POS1:  k <= CNT_W'(pos) + CNT_W'(1);
      K_INC:        k <= k + CNT_W'(1);
      K_DEC:        k <= km1;
      default:      k <= k;
    endcase
  end

  // Result fields, defaulted when a transaction is taken
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      res_status <= ST_OK;
      res_index  <= '0;
      res_value  <= '0;
    end else begin
      if (cmd.status_we) begin
        res_status <= cmd.status;
      end
      unique case (cmd.ridx_op)
        RIDX_POS:   res_index <= pos;
        RIDX_COUNT: res_index <= count[ADDR_W-1:0];
        RIDX_K:     res_index <= k[ADDR_W-1:0];
        default:    res_index <= res_index;
      endcase
      if (cmd.rval_cap) begin
        res_value <= $signed(ram_rdata);
      end
    end
  end

  // Element RAM port
  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_COUNT: ram_addr = count[ADDR_W-1:0];
      ADDR_POS:   ram_addr = pos;
      ADDR_K:     ram_addr = k[ADDR_W-1:0];
      default:    ram_addr = km1[ADDR_W-1:0];
    endcase
    ram_wdata = (cmd.wdata_sel == WD_VAL) ? val : ram_rdata;
  end

  oaids_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (cmd.ram_en),
    .we    (cmd.ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status       <= res_status;
      rsp.result_index <= res_index;
      rsp.result_value <= res_value;
      rsp.fill_count   <= count;
    end
  end

  // Status to controller
  always_comb begin
    stat.op         = op;
    stat.full       = (count == CNT_W'(DEPTH));
    stat.pos_gt_cnt = (CNT_W'(pos) > count);
    stat.pos_ge_cnt = (CNT_W'(pos) >= count);
    stat.k_gt_pos   = (k > CNT_W'(pos));
    stat.k_lt_cnt   = (k < count);
    stat.match      = (ram_rdata == val);
    stat.out_busy   = rsp_valid && !rsp_ready;
  end

endmodule

`default_nettype wire

### src/oaids_ctrl.sv
// Controller: sequences each operation over the single-port element RAM.
`default_nettype none

module oaids_ctrl import oaids_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_INSERT: begin
            if (!stat.full && !stat.pos_gt_cnt) state_next = S_INS_CHK;
            else state_next = S_RESP;
          end
          OP_DELETE: state_next = stat.pos_ge_cnt ? S_RESP : S_DEL_CAP;
          OP_SEARCH: state_next = S_SRCH_CHK;
          OP_READ:   state_next = stat.pos_ge_cnt ? S_RESP : S_RD_CAP;
          default:   state_next = S_RESP;
        endcase
      end
      S_INS_CHK:  state_next = stat.k_gt_pos ? S_INS_WR : S_RESP;
      S_INS_WR:   state_next = S_INS_CHK;
      S_DEL_CAP:  state_next = S_DEL_CHK;
      S_DEL_CHK:  state_next = stat.k_lt_cnt ? S_DEL_WR : S_RESP;
      S_DEL_WR:   state_next = S_DEL_CHK;
      S_SRCH_CHK: state_next = stat.k_lt_cnt ? S_SRCH_CMP : S_RESP;
      S_SRCH_CMP: state_next = stat.match ? S_RESP : S_SRCH_CHK;
      S_RD_CAP:   state_next = S_RESP;
      S_RESP: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready     = 1'b0;
    cmd           = '0;
    cmd.addr_sel  = ADDR_COUNT;
    cmd.wdata_sel = WD_VAL;
    cmd.cnt_op    = CNT_HOLD;
    cmd.k_op      = K_HOLD;
    cmd.status    = ST_OK;
    cmd.ridx_op   = RIDX_HOLD;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.latch = req_valid;
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_CLEAR: cmd.cnt_op = CNT_CLEAR;
          OP_APPEND: begin
            if (stat.full) begin
              cmd.status_we = 1'b1;
              cmd.status    = ST_FULL;
            end else begin
              cmd.ram_en   = 1'b1;
              cmd.ram_we   = 1'b1;
              cmd.addr_sel = ADDR_COUNT;
              cmd.ridx_op  = RIDX_COUNT;
              cmd.cnt_op   = CNT_INC;
            end
          end
          OP_INSERT: begin
            cmd.ridx_op = RIDX_POS;
            // full is checked before range
            if (stat.full) begin
              cmd.status_we = 1'b1;
              cmd.status    = ST_FULL;
            end else if (stat.pos_gt_cnt) begin
              cmd.status_we = 1'b1;
              cmd.status    = ST_RANGE;
            end else begin
              cmd.k_op = K_LOAD_COUNT;
            end
          end
          OP_DELETE, OP_READ: begin
            cmd.ridx_op = RIDX_POS;
            if (stat.pos_ge_cnt) begin
              cmd.status_we = 1'b1;
              cmd.status    = ST_RANGE;
            end else begin
              cmd.ram_en   = 1'b1;
              cmd.addr_sel = ADDR_POS;
            end
          end
          OP_SEARCH: begin
            cmd.status_we = 1'b1;
            cmd.status    = ST_MISS;
            cmd.k_op      = K_LOAD_ZERO;
          end
          default: ;
        endcase
      end
      // Shift up from the top, one read then one write per entry
      S_INS_CHK: begin
        cmd.ram_en = 1'b1;
        if (stat.k_gt_pos) begin
          cmd.addr_sel = ADDR_KM1;
        end else begin
          cmd.ram_we   = 1'b1;
          cmd.addr_sel = ADDR_POS;
          cmd.cnt_op   = CNT_INC;
        end
      end
      S_INS_WR: begin
        cmd.ram_en    = 1'b1;
        cmd.ram_we    = 1'b1;
        cmd.addr_sel  = ADDR_K;
        cmd.wdata_sel = WD_RDATA;
        cmd.k_op      = K_DEC;
      end
      // Deleted word, then shift down
      S_DEL_CAP: begin
        cmd.rval_cap = 1'b1;
        cmd.k_op     = K_LOAD_POS1;
      end
      S_DEL_CHK: begin
        if (stat.k_lt_cnt) begin
          cmd.ram_en   = 1'b1;
          cmd.addr_sel = ADDR_K;
        end else begin
          cmd.cnt_op = CNT_DEC;
        end
      end
      S_DEL_WR: begin
        cmd.ram_en    = 1'b1;
        cmd.ram_we    = 1'b1;
        cmd.addr_sel  = ADDR_KM1;
        cmd.wdata_sel = WD_RDATA;
        cmd.k_op      = K_INC;
      end
      // Linear search from index zero
      S_SRCH_CHK: begin
        if (stat.k_lt_cnt) begin
          cmd.ram_en   = 1'b1;
          cmd.addr_sel = ADDR_K;
        end
      end
      S_SRCH_CMP: begin
        if (stat.match) begin
          cmd.status_we = 1'b1;
          cmd.status    = ST_OK;
          cmd.ridx_op   = RIDX_K;
        end else begin
          cmd.k_op = K_INC;
        end
      end
      S_RD_CAP: cmd.rval_cap = 1'b1;
      S_RESP:   cmd.out_load = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### src/ordered_array_insert_delete_search.sv
// Usage:
// Fixed-depth list of signed 32-bit words with a fill count. Requests go in on
// the req channel (opcode, position, item_value); each request transaction
// yields exactly one response transaction on rsp (status, result_index,
// result_value, fill_count after the operation).
// One request is worked at a time. req_ready is high while the controller is
// idle, also while an earlier response still waits in the output register.
// Clear, append, an unknown opcode and any rejected request finish without a
// walk; read takes one RAM read. Insert shifts the n - p entries at and above
// position p up by one, delete shifts the entries above p down, and search
// compares from index zero to the first hit or through all n entries, with
// n = count and p = position. Each entry moved or compared takes one read and
// one write or compare on the single-port element RAM.
// The next request is taken in the cycle after the response loads, once the
// controller is back in idle.
// Reset empties the list at once (fill count zero, no clearing pass) and drops
// any pending response. If rsp_ready is low the response holds in its register
// and the next request is taken but not finished until the register frees.
`default_nettype none

module ordered_array_insert_delete_search import oaids_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  oaids_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  oaids_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

### src/oaids_checker.sv
// Port-level checker for the ordered array block, bound to the top level.
`default_nettype none

module oaids_checker import oaids_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);

  // Requests taken whose responses are not yet delivered
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // One request at a time: ready drops after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  // No response without a request behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response without an outstanding request");

  // Reset drops any response
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind ordered_array_insert_delete_search oaids_checker u_oaids_checker (.*);

`default_nettype wire

### test/tb_top.sv
// Testbench for the ordered array block: directed table then random list operations.
`default_nettype none

module tb_top;
  import oaids_pkg::*;

  // Opcodes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_PCT     = 29;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 160;

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  typedef enum {GROW, SHRINK, MIXED} walk_mode_t;

  typedef struct {
    req_t stim;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // Shadow copy of the list
  logic signed [DATA_W-1:0] list_words [DEPTH];
  int                       list_len;

  rsp_t       pending_rsp [$];
  dir_row_t   dir_rows [$];
  rsp_t       oldest_rsp;
  int         error_total;
  int         stall_cycles;
  bit         calm;
  walk_mode_t walk_mode;

  ordered_array_insert_delete_search dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic rsp_t mk_rsp(status_t s, int idx, logic signed [DATA_W-1:0] v, int n);
    rsp_t o;
    o.status       = s;
    o.result_index = idx[ADDR_W-1:0];
    o.result_value = v;
    o.fill_count   = n[CNT_W-1:0];
    return o;
  endfunction

  // Apply one request to the shadow list and return the response it should give
  function automatic rsp_t list_apply(req_t r);
    rsp_t o;
    int   k;
    bit   found;
    o.status       = ST_OK;
    o.result_index = '0;
    o.result_value = '0;
    found          = 1'b0;
    case (r.opcode)
      OP_CLEAR: begin
        list_len = 0;
      end
      OP_APPEND: begin
        if (list_len >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          list_words[list_len] = r.item_value;
          o.result_index = list_len[ADDR_W-1:0];
          list_len++;
        end
      end
      OP_INSERT: begin
        o.result_index = r.position;
        if (list_len >= DEPTH) begin
          o.status = ST_FULL;
        end else if (int'(r.position) > list_len) begin
          o.status = ST_RANGE;
        end else begin
          for (k = list_len; k > int'(r.position); k--) list_words[k] = list_words[k-1];
          list_words[r.position] = r.item_value;
          list_len++;
        end
      end
      OP_DELETE: begin
        o.result_index = r.position;
        if (int'(r.position) >= list_len) begin
          o.status = ST_RANGE;
        end else begin
          o.result_value = list_words[r.position];
          for (k = int'(r.position) + 1; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
        end
      end
      OP_SEARCH: begin
        o.status = ST_MISS;
        for (k = 0; k < list_len; k++) begin
          if (!found && list_words[k] == r.item_value) begin
            found          = 1'b1;
            o.status       = ST_OK;
            o.result_index = k[ADDR_W-1:0];
          end
        end
      end
      OP_READ: begin
        o.result_index = r.position;
        if (int'(r.position) >= list_len) o.status = ST_RANGE;
        else o.result_value = list_words[r.position];
      end
      default: begin
      end
    endcase
    o.fill_count = list_len[CNT_W-1:0];
    return o;
  endfunction

  function automatic void plan(logic [OP_W-1:0] op, int pos, logic signed [DATA_W-1:0] v,
                               bit typed, rsp_t want);
    dir_row_t row;
    row.stim.opcode     = op;
    row.stim.position   = pos[ADDR_W-1:0];
    row.stim.item_value = v;
    row.typed           = typed;
    row.want            = want;
    dir_rows.push_back(row);
  endfunction

  // Word values: extremes, small values that repeat, and anything
  function automatic logic signed [DATA_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      case ($urandom_range(0, 3))
        0: return WORD_MIN;
        1: return WORD_MAX;
        2: return '0;
        default: return -1;
      endcase
    end
    if (roll < 40) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  // Next random request, shaped by the current fill level
  function automatic req_t next_request();
    req_t r;
    int   roll;
    r.position   = ADDR_W'($urandom_range(0, DEPTH - 1));
    r.item_value = pick_word();
    if (list_len >= DEPTH && $urandom_range(0, 3) == 0) walk_mode = SHRINK;
    if (list_len == 0 && walk_mode == SHRINK) walk_mode = ($urandom_range(0, 1) != 0) ? GROW : MIXED;
    if (walk_mode == MIXED && $urandom_range(0, 49) == 0) walk_mode = GROW;
    roll = $urandom_range(0, 99);
    if (roll < 1) begin
      r.opcode = OP_CLEAR;
    end else if (roll < 2) begin
      r.opcode = ($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7;
    end else begin
      roll = $urandom_range(0, 99);
      case (walk_mode)
        GROW:    r.opcode = roll < 45 ? OP_APPEND : roll < 70 ? OP_INSERT : roll < 80 ? OP_SEARCH :
                            roll < 90 ? OP_READ : OP_DELETE;
        SHRINK:  r.opcode = roll < 50 ? OP_DELETE : roll < 60 ? OP_INSERT : roll < 75 ? OP_SEARCH :
                            roll < 90 ? OP_READ : OP_APPEND;
        default: r.opcode = roll < 20 ? OP_APPEND : roll < 40 ? OP_INSERT : roll < 60 ? OP_DELETE :
                            roll < 80 ? OP_SEARCH : OP_READ;
      endcase
    end
    // Mostly legal positions and search values that hit
    if (r.opcode == OP_INSERT && $urandom_range(0, 99) < 85) begin
      r.position = ADDR_W'((list_len >= DEPTH) ? $urandom_range(0, DEPTH - 1)
                                               : $urandom_range(0, list_len));
    end
    if ((r.opcode == OP_DELETE || r.opcode == OP_READ) && list_len > 0 &&
        $urandom_range(0, 99) < 85) begin
      r.position = ADDR_W'($urandom_range(0, list_len - 1));
    end
    if (r.opcode == OP_SEARCH && list_len > 0 && $urandom_range(0, 99) < 70) begin
      r.item_value = list_words[$urandom_range(0, list_len - 1)];
    end
    return r;
  endfunction

  // Drive one request transaction and record its expected response on acceptance
  task automatic send_item(req_t r, bit typed, rsp_t want);
    rsp_t model_out;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    model_out = list_apply(r);
    pending_rsp.push_back(typed ? want : model_out);
    @(negedge clk);
  endtask

  task automatic report_field(string field, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
      error_total++;
    end
  endtask

  // Response side stalls
  always @(negedge clk) begin
    rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each response transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with none expected, actual status %0d index %0d value %0d count %0d",
                 $time, rsp.status, rsp.result_index, $signed(rsp.result_value), rsp.fill_count);
        error_total++;
      end else begin
        oldest_rsp = pending_rsp.pop_front();
        report_field("status", oldest_rsp.status, rsp.status);
        report_field("result_index", oldest_rsp.result_index, rsp.result_index);
        report_field("result_value", $signed(oldest_rsp.result_value), $signed(rsp.result_value));
        report_field("fill_count", oldest_rsp.fill_count, rsp.fill_count);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL ordered_array_insert_delete_search");
        $finish;
      end
    end
  end

  initial begin
    int   real_items;
    int   i;
    req_t r;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    rsp_ready    = 1'b0;
    calm         = 1'b0;
    error_total  = 0;
    stall_cycles = 0;
    list_len     = 0;
    walk_mode    = GROW;
    for (i = 0; i < DEPTH; i++) list_words[i] = '0;

    // Empty list, bounds, extremes, shifting, first-match search, ignored codes
    plan(OP_READ,   0,  0,        1, mk_rsp(ST_RANGE, 0, 0, 0));
    plan(OP_DELETE, 63, 0,        1, mk_rsp(ST_RANGE, 63, 0, 0));
    plan(OP_SEARCH, 0,  0,        1, mk_rsp(ST_MISS, 0, 0, 0));
    plan(OP_INSERT, 1,  3,        1, mk_rsp(ST_RANGE, 1, 0, 0));
    plan(OP_APPEND, 0,  WORD_MIN, 1, mk_rsp(ST_OK, 0, 0, 1));
    plan(OP_APPEND, 63, WORD_MAX, 1, mk_rsp(ST_OK, 1, 0, 2));
    plan(OP_INSERT, 0,  -1,       1, mk_rsp(ST_OK, 0, 0, 3));
    plan(OP_INSERT, 3,  5,        1, mk_rsp(ST_OK, 3, 0, 4));
    plan(OP_READ,   0,  0,        1, mk_rsp(ST_OK, 0, -1, 4));
    plan(OP_READ,   1,  0,        1, mk_rsp(ST_OK, 1, WORD_MIN, 4));
    plan(OP_SEARCH, 0,  WORD_MAX, 1, mk_rsp(ST_OK, 2, 0, 4));
    plan(OP_SEARCH, 0,  12345,    1, mk_rsp(ST_MISS, 0, 0, 4));
    plan(OP_INSERT, 2,  7,        0, '0);
    plan(OP_APPEND, 0,  7,        0, '0);
    plan(OP_SEARCH, 0,  7,        0, '0);
    plan(OP_DELETE, 0,  0,        1, mk_rsp(ST_OK, 0, -1, 5));
    plan(OP_DELETE, 4,  0,        1, mk_rsp(ST_OK, 4, 7, 4));
    plan(OP_READ,   4,  0,        1, mk_rsp(ST_RANGE, 4, 0, 4));
    plan(OP_SPARE6, 63, -1,       1, mk_rsp(ST_OK, 0, 0, 4));
    plan(OP_SPARE7, 21, WORD_MAX, 1, mk_rsp(ST_OK, 0, 0, 4));
    plan(OP_INSERT, 63, 9,        1, mk_rsp(ST_RANGE, 63, 0, 4));
    plan(OP_DELETE, 1,  0,        0, '0);
    plan(OP_CLEAR,  42, -1,       1, mk_rsp(ST_OK, 0, 0, 0));
    plan(OP_READ,   0,  0,        1, mk_rsp(ST_RANGE, 0, 0, 0));
    plan(OP_APPEND, 0,  0,        1, mk_rsp(ST_OK, 0, 0, 1));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[j]) send_item(dir_rows[j].stim, dir_rows[j].typed, dir_rows[j].want);

    // Random walk between empty and full; ignored opcodes do not count
    real_items = 0;
    while (real_items < RANDOM_ITEMS) begin
      calm = (real_items >= 800 && real_items < 1100);
      r = next_request();
      send_item(r, 1'b0, '0);
      if (r.opcode != OP_SPARE6 && r.opcode != OP_SPARE7) real_items++;
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_total == 0 && pending_rsp.size() == 0) begin
      $display("PASS ordered_array_insert_delete_search");
    end else begin
      $display("FAIL ordered_array_insert_delete_search");
    end
    $finish;
  end

endmodule

`default_nettype wire
